@@ rtl/mpb_pkg.sv @@
// shared types and constants of the power heuristic blend
package mpb_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int WEIGHT_W   = 17;
    localparam int DEN_W      = 31;
    localparam int CELL_COUNT = WEIGHT_W - 1;
    localparam logic [DEN_W-1:0] DEN_MAX = '1;

    typedef struct packed {
        logic signed [31:0] brdf_red;
        logic signed [31:0] brdf_green;
        logic signed [31:0] brdf_blue;
        logic signed [31:0] brdf_density;
        logic signed [31:0] light_red;
        logic signed [31:0] light_green;
        logic signed [31:0] light_blue;
        logic signed [31:0] light_density;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0]    mix_red;
        logic signed [31:0]    mix_green;
        logic signed [31:0]    mix_blue;
        logic [WEIGHT_W-1:0]   brdf_weight;
        logic [WEIGHT_W-1:0]   light_weight;
    } out_item_t;

    typedef struct packed {
        logic signed [31:0] red;
        logic signed [31:0] green;
        logic signed [31:0] blue;
    } rgb_t;

    // item as it travels down the divider cells
    typedef struct packed {
        rgb_t                brdf_rgb;
        rgb_t                light_rgb;
        logic [DEN_W-1:0]    den;
        logic [DEN_W-1:0]    rem_b;
        logic [DEN_W-1:0]    rem_l;
        logic [WEIGHT_W-1:0] quo_b;
        logic [WEIGHT_W-1:0] quo_l;
        logic                zero;
    } cell_item_t;

endpackage

@@ rtl/mpb_if.sv @@
// valid/ready channels for sample and result items
interface mpb_in_if;
    logic              valid;
    logic              ready;
    mpb_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mpb_out_if;
    logic               valid;
    logic               ready;
    mpb_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/mpb_front.sv @@
// squares of both densities, saturated denominator and first quotient bit
module mpb_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  mpb_pkg::in_item_t      in_item,
    output logic                   in_ready,
    output logic                   out_valid,
    output mpb_pkg::cell_item_t    out_item,
    input  logic                   out_ready
);
    logic               sq_valid_reg;
    logic signed [63:0] sq_b_reg;
    logic signed [63:0] sq_l_reg;
    logic               nonpos_reg;
    mpb_pkg::rgb_t      brgb_reg;
    mpb_pkg::rgb_t      lrgb_reg;
    logic               sq_ready;

    logic                  div_valid_reg;
    mpb_pkg::cell_item_t   div_reg;
    mpb_pkg::cell_item_t   div_next;

    logic [mpb_pkg::DEN_W-1:0] sat_b;
    logic [mpb_pkg::DEN_W-1:0] sat_l;
    logic [mpb_pkg::DEN_W:0]   sum;
    logic [mpb_pkg::DEN_W-1:0] den;
    logic                      ge_b;
    logic                      ge_l;

    assign in_ready = !sq_valid_reg || sq_ready;
    assign sq_ready = !div_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg  <= 1'b0;
            div_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                sq_valid_reg <= in_valid;
            if (sq_ready)
                div_valid_reg <= sq_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            sq_b_reg   <= in_item.brdf_density * in_item.brdf_density;
            sq_l_reg   <= in_item.light_density * in_item.light_density;
            nonpos_reg <= (in_item.brdf_density <= 0) && (in_item.light_density <= 0);
            brgb_reg   <= '{in_item.brdf_red, in_item.brdf_green, in_item.brdf_blue};
            lrgb_reg   <= '{in_item.light_red, in_item.light_green, in_item.light_blue};
        end
        if (sq_ready)
            div_reg <= div_next;
    end

    // square shifted down by the fraction, clipped to the positive range
    always_comb
    begin
        sat_b = (|sq_b_reg[63:47]) ? mpb_pkg::DEN_MAX : sq_b_reg[46:16];
        sat_l = (|sq_l_reg[63:47]) ? mpb_pkg::DEN_MAX : sq_l_reg[46:16];
        sum   = {1'b0, sat_b} + {1'b0, sat_l};
        den   = sum[mpb_pkg::DEN_W] ? mpb_pkg::DEN_MAX : sum[mpb_pkg::DEN_W-1:0];
        ge_b  = sat_b >= den;
        ge_l  = sat_l >= den;
        div_next.brdf_rgb  = brgb_reg;
        div_next.light_rgb = lrgb_reg;
        div_next.den       = den;
        div_next.rem_b     = ge_b ? sat_b - den : sat_b;
        div_next.rem_l     = ge_l ? sat_l - den : sat_l;
        div_next.quo_b     = {{(mpb_pkg::WEIGHT_W-1){1'b0}}, ge_b};
        div_next.quo_l     = {{(mpb_pkg::WEIGHT_W-1){1'b0}}, ge_l};
        div_next.zero      = nonpos_reg || (den == '0);
    end

    assign out_valid = div_valid_reg;
    assign out_item  = div_reg;
endmodule

@@ rtl/mpb_cell.sv @@
// one restoring division step for both weights
module mpb_cell (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  mpb_pkg::cell_item_t    in_item,
    output logic                   in_ready,
    output logic                   out_valid,
    output mpb_pkg::cell_item_t    out_item,
    input  logic                   out_ready
);
    logic                  valid_reg;
    mpb_pkg::cell_item_t   item_reg;
    mpb_pkg::cell_item_t   item_next;
    logic [mpb_pkg::DEN_W:0] rem2_b;
    logic [mpb_pkg::DEN_W:0] rem2_l;
    logic [mpb_pkg::DEN_W:0] dext;
    logic [mpb_pkg::DEN_W:0] diff_b;
    logic [mpb_pkg::DEN_W:0] diff_l;
    logic                    ge_b;
    logic                    ge_l;

    assign in_ready = !valid_reg || out_ready;

    // the partial remainder stays below the denominator, so the top bit is always clear
    always_comb
    begin
        dext      = {1'b0, in_item.den};
        rem2_b    = {in_item.rem_b, 1'b0};
        rem2_l    = {in_item.rem_l, 1'b0};
        ge_b      = rem2_b >= dext;
        ge_l      = rem2_l >= dext;
        diff_b    = rem2_b - dext;
        diff_l    = rem2_l - dext;
        item_next = in_item;
        item_next.rem_b = ge_b ? diff_b[mpb_pkg::DEN_W-1:0] : rem2_b[mpb_pkg::DEN_W-1:0];
        item_next.rem_l = ge_l ? diff_l[mpb_pkg::DEN_W-1:0] : rem2_l[mpb_pkg::DEN_W-1:0];
        item_next.quo_b = {in_item.quo_b[mpb_pkg::WEIGHT_W-2:0], ge_b};
        item_next.quo_l = {in_item.quo_l[mpb_pkg::WEIGHT_W-2:0], ge_l};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;
endmodule

@@ rtl/mpb_back.sv @@
// weighting of the radiances and saturated sum into the result register
module mpb_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  mpb_pkg::cell_item_t    in_item,
    output logic                   in_ready,
    output logic                   out_valid,
    output mpb_pkg::out_item_t     out_item,
    input  logic                   out_ready
);
    logic                           mul_valid_reg;
    logic signed [49:0]             pb_reg [3];
    logic signed [49:0]             pl_reg [3];
    logic [mpb_pkg::WEIGHT_W-1:0]   wb_reg;
    logic [mpb_pkg::WEIGHT_W-1:0]   wl_reg;
    logic                           mul_ready;
    logic [mpb_pkg::WEIGHT_W-1:0]   wb;
    logic [mpb_pkg::WEIGHT_W-1:0]   wl;
    logic signed [31:0]             cb [3];
    logic signed [31:0]             cl [3];

    logic               res_valid_reg;
    mpb_pkg::out_item_t res_reg;
    logic signed [31:0] mix [3];

    assign in_ready  = !mul_valid_reg || mul_ready;
    assign mul_ready = !res_valid_reg || out_ready;

    always_comb
    begin
        wb    = in_item.zero ? '0 : in_item.quo_b;
        wl    = in_item.zero ? '0 : in_item.quo_l;
        cb[0] = in_item.brdf_rgb.red;
        cb[1] = in_item.brdf_rgb.green;
        cb[2] = in_item.brdf_rgb.blue;
        cl[0] = in_item.light_rgb.red;
        cl[1] = in_item.light_rgb.green;
        cl[2] = in_item.light_rgb.blue;
    end

    // floor shift of each product, then add and clip
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            logic signed [33:0] tb;
            logic signed [33:0] tl;
            logic signed [34:0] s;
            tb = 34'(pb_reg[c] >>> mpb_pkg::FRAC_BITS);
            tl = 34'(pl_reg[c] >>> mpb_pkg::FRAC_BITS);
            s  = 35'(tb) + 35'(tl);
            if (s > 35'sd2147483647)
                mix[c] = 32'sh7fffffff;
            else if (s < -35'sd2147483648)
                mix[c] = 32'sh80000000;
            else
                mix[c] = 32'(s);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                mul_valid_reg <= in_valid;
            if (mul_ready)
                res_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            for (int c = 0; c < 3; c++)
            begin
                pb_reg[c] <= cb[c] * $signed({1'b0, wb});
                pl_reg[c] <= cl[c] * $signed({1'b0, wl});
            end
            wb_reg <= wb;
            wl_reg <= wl;
        end
        if (mul_ready)
        begin
            res_reg.mix_red      <= mix[0];
            res_reg.mix_green    <= mix[1];
            res_reg.mix_blue     <= mix[2];
            res_reg.brdf_weight  <= wb_reg;
            res_reg.light_weight <= wl_reg;
        end
    end

    assign out_valid = res_valid_reg;
    assign out_item  = res_reg;
endmodule

@@ rtl/mis_power_heuristic_blend.sv @@
// top level: power heuristic weights and weighted radiance of a sample pair
// stages from accepted item to result valid: 2 in the front, 16 cells, 2 in the back
// throughput: one item per cycle while results are taken; every stage holds one item and moves on when the next
// stage is empty or moving, so a stalled result only blocks once the chain is full
// reset: rst_n asynchronous active low clears all stage valid flags, payload is not reset
module mis_power_heuristic_blend (
    input  logic        clk,
    input  logic        rst_n,
    mpb_in_if.sink      smp,
    mpb_out_if.source   res
);
    // handshake and payload between the divider cells
    logic                  chain_valid [mpb_pkg::CELL_COUNT+1];
    logic                  chain_ready [mpb_pkg::CELL_COUNT+1];
    mpb_pkg::cell_item_t   chain_item  [mpb_pkg::CELL_COUNT+1];

    // squares, denominator and top quotient bit
    mpb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (smp.valid),
        .in_item   (smp.data),
        .in_ready  (smp.ready),
        .out_valid (chain_valid[0]),
        .out_item  (chain_item[0]),
        .out_ready (chain_ready[0])
    );

    // one quotient bit per cell for both weights, sharing the denominator
    for (genvar i = 0; i < mpb_pkg::CELL_COUNT; i++)
    begin : g_cell
        mpb_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_item   (chain_item[i]),
            .in_ready  (chain_ready[i]),
            .out_valid (chain_valid[i+1]),
            .out_item  (chain_item[i+1]),
            .out_ready (chain_ready[i+1])
        );
    end

    // zero weights forced here, then the colour products and the clipped sum
    mpb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[mpb_pkg::CELL_COUNT]),
        .in_item   (chain_item[mpb_pkg::CELL_COUNT]),
        .in_ready  (chain_ready[mpb_pkg::CELL_COUNT]),
        .out_valid (res.valid),
        .out_item  (res.data),
        .out_ready (res.ready)
    );

`ifndef SYNTHESIS
    // weights never exceed one
    a_brdf_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.data.brdf_weight <= 17'd65536)
        else $error("brdf weight above one");

    a_light_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> res.data.light_weight <= 17'd65536)
        else $error("light weight above one");

    // an empty result register can never hold the chain up
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !res.valid |-> smp.ready)
        else $error("input stalled with empty result stage");
`endif
endmodule

@@ dv/tb_mis_power_heuristic_blend.sv @@
// testbench of the power heuristic blend: scoreboard class, drivers and top module
module tb_mis_power_heuristic_blend;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD  = 4;
    localparam int LATENCY     = 20;
    localparam int N_DIRECTED  = 24;
    localparam int N_RANDOM    = 1150;
    localparam int CYCLE_LIMIT = 200000;

    // scoreboard: predicts the blend and holds the results still due
    class blend_scoreboard;
        mpb_pkg::out_item_t due_q[$];
        int                 fails;

        function new();
            fails = 0;
        endfunction

        static function longint sat_s32(longint v);
            if (v > 64'sd2147483647)
            begin
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648)
            begin
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // fixed-point shift down by the fraction with floor rounding
        static function longint fx_shift(longint p);
            return p >>> mpb_pkg::FRAC_BITS;
        endfunction

        static function longint power_weight(longint a, longint b);
            longint sq_a;
            longint sq_b;
            longint den;
            if (a <= 0 && b <= 0)
            begin
                return 0;
            end
            sq_a = sat_s32(fx_shift(a * a));
            sq_b = sat_s32(fx_shift(b * b));
            den  = sat_s32(sq_a + sq_b);
            if (den == 0)
            begin
                return 0;
            end
            return (sq_a <<< mpb_pkg::FRAC_BITS) / den;
        endfunction

        static function longint blend_channel(logic signed [31:0] b, logic signed [31:0] l,
                                              longint wb, longint wl);
            longint term_b;
            longint term_l;
            term_b = fx_shift(longint'(b) * wb);
            term_l = fx_shift(longint'(l) * wl);
            return sat_s32(term_b + term_l);
        endfunction

        function void note_sample(mpb_pkg::in_item_t s);
            mpb_pkg::out_item_t e;
            longint             wb;
            longint             wl;
            wb = power_weight(longint'(s.brdf_density), longint'(s.light_density));
            wl = power_weight(longint'(s.light_density), longint'(s.brdf_density));
            e.mix_red      = 32'(blend_channel(s.brdf_red, s.light_red, wb, wl));
            e.mix_green    = 32'(blend_channel(s.brdf_green, s.light_green, wb, wl));
            e.mix_blue     = 32'(blend_channel(s.brdf_blue, s.light_blue, wb, wl));
            e.brdf_weight  = wb[mpb_pkg::WEIGHT_W-1:0];
            e.light_weight = wl[mpb_pkg::WEIGHT_W-1:0];
            due_q.push_back(e);
        endfunction

        task report(string what, longint got, longint want);
            $display("error: %s got %0d expected %0d", what, got, want);
            fails++;
        endtask

        task check_result(mpb_pkg::out_item_t r);
            mpb_pkg::out_item_t e;
            if (due_q.size() == 0)
            begin
                report("unexpected result, mix_red", r.mix_red, 0);
                return;
            end
            e = due_q.pop_front();
            if (r.mix_red !== e.mix_red)
            begin
                report("mix_red", r.mix_red, e.mix_red);
            end
            if (r.mix_green !== e.mix_green)
            begin
                report("mix_green", r.mix_green, e.mix_green);
            end
            if (r.mix_blue !== e.mix_blue)
            begin
                report("mix_blue", r.mix_blue, e.mix_blue);
            end
            if (r.brdf_weight !== e.brdf_weight)
            begin
                report("brdf_weight", r.brdf_weight, e.brdf_weight);
            end
            if (r.light_weight !== e.light_weight)
            begin
                report("light_weight", r.light_weight, e.light_weight);
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count;
    bit   feeding_done;

    mpb_in_if  smp ();
    mpb_out_if res ();

    blend_scoreboard blend_sb;

    mis_power_heuristic_blend DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (smp.sink),
        .res   (res.source)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // interesting density values: zero, tiny, one, negatives and the extremes
    function automatic logic [31:0] pick_density();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'($urandom_range(1, 255));
            2: return 32'h0001_0000;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            5: return -32'($urandom_range(1, 1 << 20));
            6: return 32'($urandom_range(1, 1 << 24));
            default: return $urandom;
        endcase
    endfunction

    // radiance: modest in half the draws, otherwise extreme or fully random
    function automatic logic [31:0] pick_radiance();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom;
            3: return $urandom;
            default: return 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
        endcase
    endfunction

    function automatic mpb_pkg::in_item_t random_sample();
        mpb_pkg::in_item_t s;
        s.brdf_red      = pick_radiance();
        s.brdf_green    = pick_radiance();
        s.brdf_blue     = pick_radiance();
        s.brdf_density  = pick_density();
        s.light_red     = pick_radiance();
        s.light_green   = pick_radiance();
        s.light_blue    = pick_radiance();
        s.light_density = pick_density();
        return s;
    endfunction

    // same radiances with both densities replaced
    function automatic mpb_pkg::in_item_t with_densities(mpb_pkg::in_item_t s,
                                                         logic [31:0] bd, logic [31:0] ld);
        mpb_pkg::in_item_t r;
        r               = s;
        r.brdf_density  = bd;
        r.light_density = ld;
        return r;
    endfunction

    // directed items: extremes, both densities non-positive, one negative,
    // squares that round to zero and saturating sums
    function automatic mpb_pkg::in_item_t directed_sample(int k);
        mpb_pkg::in_item_t s;
        logic [31:0] rad_max;
        logic [31:0] rad_min;
        rad_max = 32'h7fff_ffff;
        rad_min = 32'h8000_0000;
        s = '{rad_max, rad_min, 32'h0001_0000, 32'h0001_0000,
              rad_max, rad_min, 32'hffff_0000, 32'h0001_0000};
        case (k)
            0: s = with_densities(s, 32'h0, 32'h0);
            1: s = with_densities(s, rad_min, 32'hffff_ffff);
            2: s = with_densities(s, -32'h0001_0000, 32'h0002_0000);
            3: s = with_densities(s, 32'h1, 32'h1);
            4: s = with_densities(s, 32'd255, 32'h0);
            5: s = with_densities(s, 32'd256, 32'h0);
            6: s = with_densities(s, rad_max, rad_max);
            7: s = with_densities(s, rad_max, 32'h0);
            8: s = with_densities(s, 32'h0, rad_max);
            9: s = with_densities(s, rad_min, 32'h0000_8000);
            10: s = with_densities(s, 32'h0000_8000, rad_min);
            11: s = with_densities(s, 32'h00b5_0000, 32'h00b5_0000);
            12: s = with_densities(s, 32'h0001_0000, 32'h0003_0000);
            13: s = '{rad_max, rad_max, rad_max, 32'h0001_0000,
                      rad_max, rad_max, rad_max, 32'h0001_0000};
            14: s = '{rad_min, rad_min, rad_min, 32'h0001_0000,
                      rad_min, rad_min, rad_min, 32'h0001_0000};
            15: s = '{32'hffff_ffff, 32'h1, 32'h0, 32'hffff_ffff,
                      32'hffff_ffff, 32'h1, 32'h0, 32'h0000_0001};
            16: s = '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555,
                      32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa};
            17: s = '{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa,
                      32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555};
            18: s = with_densities(s, 32'h0000_00ff, 32'h0000_0100);
            default: s = random_sample();
        endcase
        return s;
    endfunction

    // offer one item after a random gap, hold it until it is taken
    task automatic send_sample(mpb_pkg::in_item_t s);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0)
        begin
            smp.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        smp.valid <= 1'b1;
        smp.data  <= s;
        @(posedge clk);
        while (!smp.ready)
        begin
            @(posedge clk);
        end
        blend_sb.note_sample(s);
        @(negedge clk);
    endtask

    initial
    begin
        blend_sb     = new();
        feeding_done = 1'b0;
        rst_n        = 1'b0;
        smp.valid    = 1'b0;
        smp.data     = '0;
        res.ready    = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        for (int k = 0; k < N_DIRECTED; k++)
        begin
            send_sample(directed_sample(k));
        end
        for (int k = 0; k < N_RANDOM; k++)
        begin
            // some bursts with no gaps come from the random gap draw of zero
            send_sample(random_sample());
        end
        smp.valid    <= 1'b0;
        feeding_done = 1'b1;
    end

    // result side: random stalls, sampled at the rising edge
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            stall = $urandom_range(0, 3);
            if ($urandom_range(0, 3) == 0)
            begin
                stall = 0;
            end
            if (stall != 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            while (!res.valid)
            begin
                @(posedge clk);
            end
            blend_sb.check_result(res.data);
        end
    end

    // cycle counter, end of run and timeout
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("mis_power_heuristic_blend: mismatch");
                $finish;
            end
            if (feeding_done && blend_sb.due_q.size() == 0)
            begin
                repeat (LATENCY * 2) @(posedge clk);
                if (blend_sb.fails == 0 && blend_sb.due_q.size() == 0)
                begin
                    $display("mis_power_heuristic_blend: match");
                end
                else
                begin
                    $display("mis_power_heuristic_blend: mismatch");
                end
                $finish;
            end
        end
    end
endmodule

@@ filelist.f @@
rtl/mpb_pkg.sv
rtl/mpb_if.sv
rtl/mpb_front.sv
rtl/mpb_cell.sv
rtl/mpb_back.sv
rtl/mis_power_heuristic_blend.sv
dv/tb_mis_power_heuristic_blend.sv
